@@ hdl/olm_pkg.sv @@
// shared types and constants for the optical latency measurer
// no dependencies
`default_nettype none
package olm_pkg;
    localparam int TIME_BITS_DEF        = 16;
    localparam int SAMPLE_BITS_DEF      = 12;
    localparam int TRIAL_COUNT_BITS_DEF = 20;
    localparam int MEAN_FRAC_BITS_DEF   = 8;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DURATION  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_HALF  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_CYCLES = 3'd5;

    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_RUN   = 2'd1;
    localparam logic [1:0] KIND_CAL   = 2'd2;
    localparam logic [1:0] KIND_STOP  = 2'd3;

    localparam logic [2:0] EV_NONE      = 3'd0;
    localparam logic [2:0] EV_TRIAL     = 3'd1;
    localparam logic [2:0] EV_RUN_DONE  = 3'd2;
    localparam logic [2:0] EV_RUN_STOP  = 3'd3;
    localparam logic [2:0] EV_CAL_OK    = 3'd4;
    localparam logic [2:0] EV_CAL_NONE  = 3'd5;
    localparam logic [2:0] EV_CAL_STOP  = 3'd6;

    typedef enum logic [5:0] {
        PH_IDLE     = 6'b000001,
        PH_SETTLE   = 6'b000010,
        PH_DETECT   = 6'b000100,
        PH_INTERVAL = 6'b001000,
        PH_CAL_ON   = 6'b010000,
        PH_CAL_OFF  = 6'b100000
    } phase_t;

    typedef enum logic [3:0] {
        SQ_IDLE = 4'b0001,
        SQ_DIV  = 4'b0010,
        SQ_FIN  = 4'b0100,
        SQ_OUT  = 4'b1000
    } seq_t;

    typedef enum logic [2:0] {
        DV_TRIALS = 3'b001,
        DV_MEAN   = 3'b010,
        DV_CAL    = 3'b100
    } div_op_t;
endpackage
`default_nettype wire

@@ hdl/optical_latency_measurer_unit.sv @@
// optical latency measurer: tick sequencer with one shared restoring divider
// depends on olm_pkg
//
// usage: s_axis carries one item per transaction: the kind in s_axis_tuser and
// sample_mv in s_axis_tdata[11:0]. m_axis returns exactly one result per item.
// cfg_valid/cfg_ready/cfg_index/cfg_data write the six setup registers; write
// them only while idle.
// a plain item presents its result in the cycle after acceptance. Items that
// start a run, end a run or complete a calibration use the shared restoring
// divider, one quotient bit per cycle: 20 quotient bits for the trial count, 44
// for the mean (36 sum bits plus 8 fraction bits), 32 for the calibration
// average. The last divider state writes the result for m_axis; a tick that ends
// a run or a calibration first passes SQ_FIN to load the sums.
// one item at a time: s_axis_tready is low from acceptance until the result has
// been taken on m_axis, so a new item is taken only after the last result.
// reset: all control state clears, the baseline is zero, the LED and the
// sensor are off and the registers return to their defaults.
// stall: while m_axis_tready is low the result holds and no item is taken.
`default_nettype none
module optical_latency_measurer_unit #(
    parameter int TIME_BITS        = olm_pkg::TIME_BITS_DEF,
    parameter int SAMPLE_BITS      = olm_pkg::SAMPLE_BITS_DEF,
    parameter int TRIAL_COUNT_BITS = olm_pkg::TRIAL_COUNT_BITS_DEF,
    parameter int MEAN_FRAC_BITS   = olm_pkg::MEAN_FRAC_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [1:0]  s_axis_tuser,   // kind[1:0]
    input  wire logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata, // sample_mv
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,
    // led_on[0], sensor_on[1], busy_res[2], event_res[5:3], latency_ms[22:6],
    // mean_latency_q8[46:23], run_success[47], baseline_mv[58:48],
    // cal_samples[78:59], zero at bit 79
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [olm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [19:0] cfg_data
);
    localparam int SUM_W = 36;
    localparam int CSUM_W = 32;
    localparam int DIV_W = SUM_W + MEAN_FRAC_BITS;
    localparam int DCNT_W = 6;

    logic [15:0] interval_reg, timeout_reg, settle_reg, half_reg;
    logic [19:0] duration_reg;
    logic [3:0]  cycles_reg;

    olm_pkg::phase_t phase_reg, phase_next;
    olm_pkg::seq_t   seq_reg;
    olm_pkg::div_op_t op_reg;
    logic [TIME_BITS-1:0] timer_reg;
    logic [TRIAL_COUNT_BITS-1:0] total_reg, done_reg;
    logic [SUM_W-1:0] vsum_reg;
    logic [19:0] vcount_reg;
    logic [10:0] base_reg;
    logic [CSUM_W-1:0] csum_reg;
    logic [19:0] ccount_reg;
    logic [3:0] ccycle_reg;
    logic stop_reg, led_reg, sens_reg;

    logic [DIV_W-1:0] dq_reg, dr_reg;
    logic [DIV_W-1:0] dd_reg;
    logic [DCNT_W-1:0] dcnt_reg;

    logic [2:0] ev_reg;
    logic [16:0] lat_reg;
    logic [23:0] mean_reg;
    logic succ_reg;
    logic [19:0] cs_reg;

    logic [1:0] kind;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic [29:0] thr_prod;
    logic [16:0] thr;
    logic [TIME_BITS-1:0] t_inc;
    logic [31:0] t_cmp;
    logic det_hit;
    logic [TRIAL_COUNT_BITS-1:0] quot_trials;
    logic [3:0] cc_inc;
    logic [TRIAL_COUNT_BITS-1:0] done_inc;
    logic [DIV_W:0] rem_sh;
    logic [DIV_W:0] rem_sub;

    assign kind   = s_axis_tuser;
    assign sample = s_axis_tdata[SAMPLE_BITS-1:0];
    // baseline * 6 / 5 by reciprocal multiplication
    assign thr_prod = 30'(base_reg) * 30'd314574;
    assign thr    = {5'd0, thr_prod[29:18]};
    assign t_inc  = timer_reg + 1'b1;
    assign t_cmp  = 32'(t_inc);
    assign det_hit = (sample >= $signed({1'b0, thr})) && (t_cmp <= 32'(timeout_reg));
    assign quot_trials = TRIAL_COUNT_BITS'(dq_reg[19:0]);
    assign cc_inc = ccycle_reg + 1'b1;
    assign done_inc = done_reg + 1'b1;
    assign rem_sh = {dr_reg, dq_reg[DIV_W-1]};
    assign rem_sub = rem_sh - {1'b0, dd_reg};

    assign s_axis_tready = (seq_reg == olm_pkg::SQ_IDLE);
    assign cfg_ready = 1'b1;
    assign m_axis_tvalid = (seq_reg == olm_pkg::SQ_OUT);
    assign m_axis_tdata = {1'b0, cs_reg, base_reg, succ_reg, mean_reg, lat_reg, ev_reg,
                           (phase_reg != olm_pkg::PH_IDLE), sens_reg, led_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= 16'd1000;
            duration_reg <= 20'd10000;
            timeout_reg  <= 16'd5000;
            settle_reg   <= 16'd50;
            half_reg     <= 16'd500;
            cycles_reg   <= 4'd4;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                olm_pkg::REG_INTERVAL:   interval_reg <= cfg_data[15:0];
                olm_pkg::REG_DURATION:   duration_reg <= cfg_data;
                olm_pkg::REG_TIMEOUT:    timeout_reg  <= cfg_data[15:0];
                olm_pkg::REG_SETTLE:     settle_reg   <= cfg_data[15:0];
                olm_pkg::REG_CAL_HALF:   half_reg     <= cfg_data[15:0];
                olm_pkg::REG_CAL_CYCLES: cycles_reg   <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // start of a trial: settle or straight to detection
    always_comb
    begin
        phase_next = (settle_reg == '0) ? olm_pkg::PH_DETECT : olm_pkg::PH_SETTLE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= olm_pkg::PH_IDLE;
            seq_reg   <= olm_pkg::SQ_IDLE;
            op_reg    <= olm_pkg::DV_TRIALS;
            timer_reg <= '0;
            total_reg <= '0;
            done_reg  <= '0;
            vsum_reg  <= '0;
            vcount_reg <= '0;
            base_reg  <= '0;
            csum_reg  <= '0;
            ccount_reg <= '0;
            ccycle_reg <= '0;
            stop_reg  <= 1'b0;
            led_reg   <= 1'b0;
            sens_reg  <= 1'b0;
            dq_reg <= '0; dr_reg <= '0; dd_reg <= '0; dcnt_reg <= '0;
            ev_reg <= '0; lat_reg <= '0; mean_reg <= '0; succ_reg <= 1'b0; cs_reg <= '0;
        end
        else
        begin
            unique case (seq_reg)
                olm_pkg::SQ_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        ev_reg <= olm_pkg::EV_NONE;
                        lat_reg <= '0;
                        mean_reg <= '0;
                        succ_reg <= 1'b0;
                        cs_reg <= '0;
                        seq_reg <= olm_pkg::SQ_OUT;
                        unique case (kind)
                            olm_pkg::KIND_RUN:
                            begin
                                if (phase_reg == olm_pkg::PH_IDLE && interval_reg != '0
                                    && duration_reg != '0)
                                begin
                                    done_reg <= '0;
                                    vsum_reg <= '0;
                                    vcount_reg <= '0;
                                    stop_reg <= 1'b0;
                                    sens_reg <= 1'b1;
                                    timer_reg <= '0;
                                    phase_reg <= phase_next;
                                    led_reg <= (settle_reg == '0);
                                    op_reg <= olm_pkg::DV_TRIALS;
                                    dq_reg <= DIV_W'(duration_reg) << (DIV_W - 20);
                                    dr_reg <= '0;
                                    dd_reg <= DIV_W'(interval_reg);
                                    dcnt_reg <= DCNT_W'(20);
                                    seq_reg <= olm_pkg::SQ_DIV;
                                end
                            end
                            olm_pkg::KIND_CAL:
                            begin
                                if (phase_reg == olm_pkg::PH_IDLE)
                                begin
                                    stop_reg <= 1'b0;
                                    csum_reg <= '0;
                                    ccount_reg <= '0;
                                    ccycle_reg <= '0;
                                    if (cycles_reg == '0)
                                    begin
                                        led_reg <= 1'b0;
                                        sens_reg <= 1'b0;
                                        ev_reg <= olm_pkg::EV_CAL_NONE;
                                    end
                                    else
                                    begin
                                        sens_reg <= 1'b1;
                                        led_reg <= 1'b1;
                                        phase_reg <= olm_pkg::PH_CAL_ON;
                                        timer_reg <= '0;
                                    end
                                end
                            end
                            olm_pkg::KIND_STOP:
                            begin
                                if (phase_reg == olm_pkg::PH_SETTLE
                                    || phase_reg == olm_pkg::PH_DETECT)
                                    stop_reg <= 1'b1;
                                else if (phase_reg == olm_pkg::PH_INTERVAL)
                                begin
                                    ev_reg <= olm_pkg::EV_RUN_STOP;
                                    led_reg <= 1'b0; sens_reg <= 1'b0; stop_reg <= 1'b0;
                                    phase_reg <= olm_pkg::PH_IDLE;
                                    op_reg <= olm_pkg::DV_MEAN;
                                    seq_reg <= olm_pkg::SQ_DIV;
                                    dq_reg <= DIV_W'(vsum_reg) << MEAN_FRAC_BITS;
                                    dr_reg <= '0;
                                    dd_reg <= DIV_W'(vcount_reg);
                                    dcnt_reg <= DCNT_W'(DIV_W);
                                end
                                else if (phase_reg == olm_pkg::PH_CAL_ON
                                    || phase_reg == olm_pkg::PH_CAL_OFF)
                                begin
                                    ev_reg <= olm_pkg::EV_CAL_STOP;
                                    led_reg <= 1'b0; sens_reg <= 1'b0; stop_reg <= 1'b0;
                                    phase_reg <= olm_pkg::PH_IDLE;
                                end
                            end
                            default:
                            begin
                                unique case (phase_reg)
                                    olm_pkg::PH_SETTLE:
                                    begin
                                        timer_reg <= t_inc;
                                        if (t_cmp >= 32'(settle_reg))
                                        begin
                                            phase_reg <= olm_pkg::PH_DETECT;
                                            led_reg <= 1'b1;
                                            timer_reg <= '0;
                                        end
                                    end
                                    olm_pkg::PH_DETECT:
                                    begin
                                        timer_reg <= t_inc;
                                        if (det_hit || t_cmp >= 32'(timeout_reg))
                                        begin
                                            if (det_hit)
                                            begin
                                                lat_reg <= 17'(t_inc);
                                                vsum_reg <= vsum_reg + SUM_W'(t_inc);
                                                vcount_reg <= vcount_reg + 1'b1;
                                            end
                                            else
                                                lat_reg <= '1;
                                            led_reg <= 1'b0;
                                            done_reg <= done_inc;
                                            if (done_inc >= total_reg || stop_reg)
                                            begin
                                                ev_reg <= olm_pkg::EV_RUN_DONE;
                                                sens_reg <= 1'b0;
                                                stop_reg <= 1'b0;
                                                phase_reg <= olm_pkg::PH_IDLE;
                                                op_reg <= olm_pkg::DV_MEAN;
                                                seq_reg <= olm_pkg::SQ_FIN;
                                            end
                                            else
                                            begin
                                                ev_reg <= olm_pkg::EV_TRIAL;
                                                phase_reg <= olm_pkg::PH_INTERVAL;
                                                timer_reg <= '0;
                                            end
                                        end
                                    end
                                    olm_pkg::PH_INTERVAL:
                                    begin
                                        timer_reg <= t_inc;
                                        if (t_cmp >= 32'(interval_reg))
                                        begin
                                            timer_reg <= '0;
                                            phase_reg <= phase_next;
                                            led_reg <= (settle_reg == '0);
                                        end
                                    end
                                    olm_pkg::PH_CAL_ON:
                                    begin
                                        timer_reg <= t_inc;
                                        if (t_cmp >= 32'(half_reg))
                                        begin
                                            led_reg <= 1'b0;
                                            phase_reg <= olm_pkg::PH_CAL_OFF;
                                            timer_reg <= '0;
                                        end
                                    end
                                    olm_pkg::PH_CAL_OFF:
                                    begin
                                        if (sample > 0)
                                        begin
                                            csum_reg <= csum_reg + CSUM_W'(sample);
                                            ccount_reg <= ccount_reg + 1'b1;
                                        end
                                        timer_reg <= t_inc;
                                        if (t_cmp >= 32'(half_reg))
                                        begin
                                            ccycle_reg <= cc_inc;
                                            if (cc_inc >= cycles_reg || cc_inc == '0)
                                            begin
                                                led_reg <= 1'b0;
                                                sens_reg <= 1'b0;
                                                stop_reg <= 1'b0;
                                                phase_reg <= olm_pkg::PH_IDLE;
                                                op_reg <= olm_pkg::DV_CAL;
                                                seq_reg <= olm_pkg::SQ_FIN;
                                            end
                                            else
                                            begin
                                                led_reg <= 1'b1;
                                                phase_reg <= olm_pkg::PH_CAL_ON;
                                                timer_reg <= '0;
                                            end
                                        end
                                    end
                                    default: ;
                                endcase
                            end
                        endcase
                    end
                end
                // load the divider with sums updated on the accepting edge
                olm_pkg::SQ_FIN:
                begin
                    dr_reg <= '0;
                    seq_reg <= olm_pkg::SQ_DIV;
                    if (op_reg == olm_pkg::DV_MEAN)
                    begin
                        dq_reg <= DIV_W'(vsum_reg) << MEAN_FRAC_BITS;
                        dd_reg <= DIV_W'(vcount_reg);
                        dcnt_reg <= DCNT_W'(DIV_W);
                    end
                    else
                    begin
                        dq_reg <= DIV_W'(csum_reg) << (DIV_W - CSUM_W);
                        dd_reg <= DIV_W'(ccount_reg);
                        dcnt_reg <= DCNT_W'(CSUM_W);
                    end
                end
                olm_pkg::SQ_DIV:
                begin
                    if (dcnt_reg != '0)
                    begin
                        dcnt_reg <= dcnt_reg - 1'b1;
                        if (!rem_sub[DIV_W])
                        begin
                            dr_reg <= rem_sub[DIV_W-1:0];
                            dq_reg <= {dq_reg[DIV_W-2:0], 1'b1};
                        end
                        else
                        begin
                            dr_reg <= rem_sh[DIV_W-1:0];
                            dq_reg <= {dq_reg[DIV_W-2:0], 1'b0};
                        end
                    end
                    else
                    begin
                        seq_reg <= olm_pkg::SQ_OUT;
                        unique case (op_reg)
                            olm_pkg::DV_TRIALS:
                                total_reg <= (quot_trials == '0) ? TRIAL_COUNT_BITS'(1)
                                             : quot_trials;
                            olm_pkg::DV_MEAN:
                            begin
                                mean_reg <= (dd_reg == '0) ? '0 : dq_reg[23:0];
                                succ_reg <= (dd_reg != '0) && (dq_reg[23:0] != '0);
                            end
                            default:
                            begin
                                if (dd_reg == '0)
                                    ev_reg <= olm_pkg::EV_CAL_NONE;
                                else
                                begin
                                    ev_reg <= olm_pkg::EV_CAL_OK;
                                    base_reg <= dq_reg[10:0];
                                    cs_reg <= ccount_reg;
                                    succ_reg <= 1'b1;
                                end
                            end
                        endcase
                    end
                end
                default:
                begin
                    if (m_axis_tready)
                        seq_reg <= olm_pkg::SQ_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire
